>>> hdl/pwle_pkg.sv
// shared types, register indexes and segment table helpers for the envelope core
package pwle_pkg;

  localparam int MAX_SEGMENTS_DEF = 8;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [2:0] REG_START_GAIN   = 3'd0;
  localparam logic [2:0] REG_SEG_COUNT    = 3'd1;
  localparam logic [2:0] REG_SEGMENTS_0_1 = 3'd2;
  localparam logic [2:0] REG_SEGMENTS_2_3 = 3'd3;
  localparam logic [2:0] REG_SEGMENTS_4_5 = 3'd4;
  localparam logic [2:0] REG_SEGMENTS_6_7 = 3'd5;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               start;
  } item_t;

  typedef struct packed {
    logic [15:0]         start_gain;
    logic [3:0]          count;
    logic [3:0][63:0]    seg;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETTLE_A,
    ST_PROD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL,
    ST_SCALE,
    ST_SETTLE_B,
    ST_EMIT
  } state_t;

  function automatic logic [15:0] seg_end(input logic [3:0][63:0] seg, input logic [2:0] k);
    logic [63:0] w;
    w = seg[k[2:1]];
    return k[0] ? w[47:32] : w[15:0];
  endfunction

  function automatic logic [15:0] seg_len(input logic [3:0][63:0] seg, input logic [2:0] k);
    logic [63:0] w;
    w = seg[k[2:1]];
    return k[0] ? w[63:48] : w[31:16];
  endfunction

endpackage

>>> hdl/pwle_fifo.sv
// input queue between the accepting front and the envelope back end
module pwle_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pwle_pkg::item_t  wr_item,
  output logic             rd_valid,
  input  logic             rd_pop,
  output pwle_pkg::item_t  rd_item
);

  pwle_pkg::item_t mem [pwle_pkg::FIFO_DEPTH];
  logic [pwle_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [pwle_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [pwle_pkg::FIFO_PTR_W:0]   fill;
  logic push;
  logic pop;

  assign in_stall = (fill == (pwle_pkg::FIFO_PTR_W+1)'(pwle_pkg::FIFO_DEPTH));
  assign rd_valid = (fill != '0);
  assign push = in_valid && !in_stall;
  assign pop = rd_pop && rd_valid;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == pwle_pkg::FIFO_PTR_W'(pwle_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == pwle_pkg::FIFO_PTR_W'(pwle_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (pwle_pkg::FIFO_PTR_W+1)'(push) - (pwle_pkg::FIFO_PTR_W+1)'(pop);
    end
  end

endmodule

>>> hdl/pwle_div.sv
// bit-serial restoring divider, 32-bit dividend by 16-bit divisor
module pwle_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [16:0] rem;
  logic [15:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] rem_sh;
  logic        take;

  assign rem_sh = {rem[15:0], quotient[31]};
  assign take = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem <= take ? rem_sh - {1'b0, dvs} : rem_sh;
      quotient <= {quotient[30:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/pwle_back.sv
// envelope sequencer: segment settling, gain interpolation, scaling and result register
module pwle_back #(
  parameter int MAX_SEGMENTS = pwle_pkg::MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pwle_pkg::cfg_t     cfg,
  input  logic               item_valid,
  output logic               item_pop,
  input  pwle_pkg::item_t    item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  output logic               frame_last_out,
  output logic [15:0]        gain_now,
  output logic               envelope_done
);

  localparam logic [3:0] MaxCnt = 4'(MAX_SEGMENTS);

  pwle_pkg::state_t state, state_next;

  logic [3:0]  idx;
  logic [15:0] pos;
  logic [15:0] from;
  logic        fin;

  pwle_pkg::item_t cur;
  logic [15:0]        gain_r;
  logic signed [15:0] y_r;
  logic               d_neg;
  logic [31:0]        prod_r;
  logic [15:0]        len_r;
  logic [15:0]        end_r;
  logic signed [32:0] mprod;

  logic [3:0]  n_act;
  logic [15:0] cur_len;
  logic [15:0] cur_end;
  logic signed [16:0] d;
  logic [15:0] d_mag;
  logic        div_start;
  logic        div_done;
  logic [31:0] quo;
  logic [31:0] quo_s;
  logic signed [32:0] adj;
  logic signed [18:0] shifted;
  logic [15:0] pos_inc;
  logic        settle_break;
  logic        out_free;

  assign n_act = (cfg.count > MaxCnt) ? MaxCnt : cfg.count;
  assign cur_len = pwle_pkg::seg_len(cfg.seg, idx[2:0]);
  assign cur_end = pwle_pkg::seg_end(cfg.seg, idx[2:0]);
  assign d = $signed({1'b0, cur_end}) - $signed({1'b0, from});
  assign d_mag = d[16] ? 16'(-d) : d[15:0];
  assign quo_s = d_neg ? (~quo + 32'd1) : quo;
  assign adj = mprod + (mprod[32] ? 33'sd16383 : 33'sd0);
  assign shifted = 19'(adj >>> 14);
  assign pos_inc = pos + 16'd1;
  assign settle_break = (idx < n_act) && (cur_len != '0);
  assign out_free = !out_valid || !out_stall;

  pwle_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      pwle_pkg::ST_IDLE:      if (item_valid) state_next = pwle_pkg::ST_SETTLE_A;
      pwle_pkg::ST_SETTLE_A: begin
        if (fin) state_next = pwle_pkg::ST_EMIT;
        else if (settle_break) state_next = pwle_pkg::ST_PROD;
      end
      pwle_pkg::ST_PROD:      state_next = pwle_pkg::ST_DIV_START;
      pwle_pkg::ST_DIV_START: state_next = pwle_pkg::ST_DIV_WAIT;
      pwle_pkg::ST_DIV_WAIT:  if (div_done) state_next = pwle_pkg::ST_MUL;
      pwle_pkg::ST_MUL:       state_next = pwle_pkg::ST_SCALE;
      pwle_pkg::ST_SCALE: begin
        if (cur.last && pos_inc >= len_r) state_next = pwle_pkg::ST_SETTLE_B;
        else state_next = pwle_pkg::ST_EMIT;
      end
      pwle_pkg::ST_SETTLE_B: if (fin || settle_break) state_next = pwle_pkg::ST_EMIT;
      pwle_pkg::ST_EMIT:      if (out_free) state_next = pwle_pkg::ST_IDLE;
      default:                state_next = pwle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop = 1'b0;
    div_start = 1'b0;
    case (state)
      pwle_pkg::ST_IDLE:      item_pop = item_valid;
      pwle_pkg::ST_DIV_START: div_start = 1'b1;
      default: begin
        item_pop = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwle_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      pos <= '0;
      from <= '0;
      fin <= 1'b1;
    end else begin
      case (state)
        pwle_pkg::ST_IDLE: begin
          if (item_valid && item.start) begin
            idx <= '0;
            pos <= '0;
            from <= cfg.start_gain;
            fin <= 1'b0;
          end
        end
        pwle_pkg::ST_SETTLE_A, pwle_pkg::ST_SETTLE_B: begin
          if (!fin) begin
            if (idx >= n_act) begin
              fin <= 1'b1;
              pos <= '0;
            end else if (cur_len == '0) begin
              from <= cur_end;
              idx <= idx + 4'd1;
              pos <= '0;
            end
          end
        end
        pwle_pkg::ST_SCALE: begin
          if (cur.last) begin
            if (pos_inc >= len_r) begin
              from <= end_r;
              idx <= idx + 4'd1;
              pos <= '0;
            end else begin
              pos <= pos_inc;
            end
          end
        end
        default: begin
          fin <= fin;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      pwle_pkg::ST_IDLE: begin
        cur <= item;
        gain_r <= '0;
        y_r <= '0;
      end
      pwle_pkg::ST_PROD: begin
        d_neg <= d[16];
        prod_r <= d_mag * pos;
        len_r <= cur_len;
        end_r <= cur_end;
      end
      pwle_pkg::ST_DIV_WAIT: begin
        if (div_done) gain_r <= from + quo_s[15:0];
      end
      pwle_pkg::ST_MUL: begin
        mprod <= cur.sample * $signed({1'b0, gain_r});
      end
      pwle_pkg::ST_SCALE: begin
        if (shifted > 19'sd32767) y_r <= 16'sh7fff;
        else if (shifted < -19'sd32768) y_r <= -16'sh8000;
        else y_r <= shifted[15:0];
      end
      default: begin
        y_r <= y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == pwle_pkg::ST_EMIT && out_free) begin
      sample_out <= y_r;
      frame_last_out <= cur.last;
      gain_now <= gain_r;
      envelope_done <= fin && (gain_r == '0) && (y_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pwle_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> hdl/piecewise_linear_envelope_core.sv
// top level of the piecewise linear gain envelope: config registers, input queue, back end
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    sample_in, frame_last, clip_start
//   output    out        out_valid / out_stall  sample_out, frame_last_out, gain_now,
//                                               envelope_done
//   config    in         cfg_write              cfg_index, cfg_data
//
// a sample with an interpolated gain runs through the product, divide, multiply and scale
// states of the back end, the divide being the 32-step serial divider; each skipped
// segment adds a settling step and a segment end adds one more. a finished envelope
// skips the interpolation and goes from settling straight to the result register.
// a two-entry queue keeps accepting input while the back end works, until it is full.
// reset is synchronous; it restores register defaults and leaves the envelope finished.
// a full result register holds while out_stall is high; the back end waits until it is empty or not stalled.
module piecewise_linear_envelope_core #(
  parameter int MAX_SEGMENTS = pwle_pkg::MAX_SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample_in,
  input  logic               frame_last,
  input  logic               clip_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  output logic               frame_last_out,
  output logic [15:0]        gain_now,
  output logic               envelope_done,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  pwle_pkg::cfg_t  cfg;
  pwle_pkg::item_t wr_item;
  pwle_pkg::item_t rd_item;
  logic rd_valid;
  logic rd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_gain <= 16'd16384;
      cfg.count <= 4'd1;
      cfg.seg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pwle_pkg::REG_START_GAIN:   cfg.start_gain <= cfg_data[15:0];
        pwle_pkg::REG_SEG_COUNT:    cfg.count <= cfg_data[3:0];
        pwle_pkg::REG_SEGMENTS_0_1: cfg.seg[0] <= cfg_data;
        pwle_pkg::REG_SEGMENTS_2_3: cfg.seg[1] <= cfg_data;
        pwle_pkg::REG_SEGMENTS_4_5: cfg.seg[2] <= cfg_data;
        pwle_pkg::REG_SEGMENTS_6_7: cfg.seg[3] <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  assign wr_item.sample = sample_in;
  assign wr_item.last = frame_last;
  assign wr_item.start = clip_start;

  pwle_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .wr_item  (wr_item),
    .rd_valid (rd_valid),
    .rd_pop   (rd_pop),
    .rd_item  (rd_item)
  );

  pwle_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item_valid     (rd_valid),
    .item_pop       (rd_pop),
    .item           (rd_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_out     (sample_out),
    .frame_last_out (frame_last_out),
    .gain_now       (gain_now),
    .envelope_done  (envelope_done)
  );

endmodule
